// ===== hdl/lpfr_pkg.sv =====
// Package for the LRU page frame replacer: sizes, codes and controller/datapath structs.
package lpfr_pkg;

   localparam int NUM_FRAMES  = 64;
   localparam int STAMP_WIDTH = 32;
   localparam int IDX_W       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W       = IDX_W + 1;

   localparam int PID_W       = 8;
   localparam int ADDR_W      = 32;
   localparam int SHIFT_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int FRAME_W     = 6;

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(12);

   typedef enum logic {
      OP_ACCESS  = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 2'd0,
      ST_MISS     = 2'd1,
      ST_RELEASED = 2'd2,
      ST_ERROR    = 2'd3
   } status_type;

   typedef struct packed {
      logic [PID_W-1:0]       owner;
      logic [ADDR_W-1:0]      page;
      logic [STAMP_WIDTH-1:0] stamp;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             cmp_en;
      logic [IDX_W-1:0] cmp_idx;
      logic             cmp_first;
      logic             commit;
      logic             rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pid_zero;
      logic is_release;
   } sts_type;

endpackage

// ===== hdl/lpfr_if.sv =====
// Channel interfaces of the LRU page frame replacer: request, response and register write.
interface lpfr_req_if import lpfr_pkg::*;;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [PID_W-1:0]  pid;
   logic [ADDR_W-1:0] address;

   modport source(output valid, opcode, pid, address, input ready);
   modport sink(input valid, opcode, pid, address, output ready);
endinterface

interface lpfr_rsp_if import lpfr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAME_W-1:0]  frame;
   logic                victim_valid;
   logic [PID_W-1:0]    victim_pid;

   modport source(output valid, status, frame, victim_valid, victim_pid, input ready);
   modport sink(input valid, status, frame, victim_valid, victim_pid, output ready);
endinterface

interface lpfr_csr_if import lpfr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SHIFT_W-1:0] page_shift;

   modport source(output valid, page_shift, input ready);
   modport sink(input valid, page_shift, output ready);
endinterface

// ===== hdl/lpfr_ctrl.sv =====
// Controller state machine of the LRU page frame replacer: sequences decode, scan and commit.
module lpfr_ctrl import lpfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cmp_en_ff, cmp_en_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             rd_en;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rd_en     = (state_ff == S_SCAN) && (cnt_ff < CNT_W'(NUM_FRAMES));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmp_en_in    = rd_en;
      cmp_idx_in   = cnt_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd           = '0;
      cmd.load      = req_valid && req_ready;
      cmd.rd_en     = rd_en;
      cmd.rd_idx    = cnt_ff[IDX_W-1:0];
      cmd.cmp_en    = cmp_en_ff;
      cmd.cmp_idx   = cmp_idx_ff;
      cmd.cmp_first = (cmp_idx_ff == '0);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cnt_in = '0;
            if (sts.pid_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // The last compare lands in the cycle after the last read is issued.
            if (cnt_ff == CNT_W'(NUM_FRAMES)) begin
               state_in = sts.is_release ? S_DONE : S_COMMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cmp_en_ff    <= 1'b0;
         cmp_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_en_ff    <= cmp_en_in;
         cmp_idx_ff   <= cmp_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/lpfr_datapath.sv =====
// Datapath of the LRU page frame replacer: frame table memory, scan compare and result register.
module lpfr_datapath import lpfr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_opcode,
   input  logic [PID_W-1:0]    req_pid,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic                csr_write,
   input  logic [SHIFT_W-1:0]  csr_page_shift,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FRAME_W-1:0]  rsp_frame,
   output logic                rsp_victim_valid,
   output logic [PID_W-1:0]    rsp_victim_pid
);

   entry_type              mem [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]  valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   logic [SHIFT_W-1:0]     page_shift_ff;
   logic [STAMP_WIDTH-1:0] next_stamp_ff;

   logic                   release_ff;
   logic                   pid_zero_ff;
   logic [PID_W-1:0]       pid_ff;
   logic [ADDR_W-1:0]      page_ff;

   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [STAMP_WIDTH-1:0] best_stamp_ff;
   logic [PID_W-1:0]       best_owner_ff;

   logic [STATUS_W-1:0]    status_ff;
   logic [FRAME_W-1:0]     frame_ff;
   logic                   victim_valid_ff;
   logic [PID_W-1:0]       victim_pid_ff;

   entry_type              cur;
   logic                   owner_match;
   logic                   we;
   logic [IDX_W-1:0]       wa;
   entry_type              wd;
   logic                   do_commit;

   // An entry never written since reset reads as a free frame with all fields zero.
   assign cur         = rd_valid_ff ? rd_data_ff : '0;
   assign owner_match = (cur.owner == pid_ff);
   assign do_commit   = cmd.commit && !release_ff;

   assign sts.pid_zero   = pid_zero_ff;
   assign sts.is_release = release_ff;

   always_comb begin
      we = 1'b0;
      wa = cmd.cmp_idx;
      wd = '0;
      if (cmd.cmp_en && release_ff && owner_match) begin
         we       = 1'b1;
         wd.stamp = STAMP_WIDTH'(1);
      end else if (do_commit) begin
         we       = 1'b1;
         wa       = hit_ff ? hit_idx_ff : best_idx_ff;
         wd.owner = pid_ff;
         wd.page  = page_ff;
         wd.stamp = next_stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         page_shift_ff <= PAGE_SHIFT_RESET;
         next_stamp_ff <= STAMP_WIDTH'(1);
         pid_zero_ff   <= 1'b0;
         release_ff    <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[wa] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.rd_idx];
         end
         if (csr_write) begin
            page_shift_ff <= csr_page_shift;
         end
         if (do_commit) begin
            next_stamp_ff <= next_stamp_ff + STAMP_WIDTH'(1);
         end
         if (cmd.load) begin
            pid_zero_ff <= (req_pid == '0);
            release_ff  <= (req_opcode == OP_RELEASE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pid_ff  <= req_pid;
         page_ff <= req_address >> page_shift_ff;
         hit_ff  <= 1'b0;
      end
      if (cmd.cmp_en) begin
         // Only the first matching frame counts as the hit.
         if (owner_match && (cur.page == page_ff) && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= cmd.cmp_idx;
         end
         // Strict compare keeps the lowest index among equal stamps.
         if (cmd.cmp_first || (cur.stamp < best_stamp_ff)) begin
            best_idx_ff   <= cmd.cmp_idx;
            best_stamp_ff <= cur.stamp;
            best_owner_ff <= cur.owner;
         end
      end
      if (cmd.rsp_load) begin
         if (pid_zero_ff) begin
            status_ff       <= ST_ERROR;
            frame_ff        <= '0;
            victim_valid_ff <= 1'b0;
            victim_pid_ff   <= '0;
         end else if (release_ff) begin
            status_ff       <= ST_RELEASED;
            frame_ff        <= '0;
            victim_valid_ff <= 1'b0;
            victim_pid_ff   <= '0;
         end else if (hit_ff) begin
            status_ff       <= ST_HIT;
            frame_ff        <= FRAME_W'(hit_idx_ff);
            victim_valid_ff <= 1'b0;
            victim_pid_ff   <= '0;
         end else begin
            status_ff       <= ST_MISS;
            frame_ff        <= FRAME_W'(best_idx_ff);
            victim_valid_ff <= (best_owner_ff != '0);
            victim_pid_ff   <= best_owner_ff;
         end
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_frame        = frame_ff;
   assign rsp_victim_valid = victim_valid_ff;
   assign rsp_victim_pid   = victim_pid_ff;

endmodule

// ===== hdl/lru_page_frame_replacer.sv =====
// Top level of the LRU page frame replacer: joins controller, datapath and channels.
//
// A request on req_ch either accesses a byte address for a process (opcode 0) or
// releases every frame of a process (opcode 1). Each request yields exactly one
// response on rsp_ch: hit, miss with the replaced frame and its previous owner,
// released, or error when the process id is zero.
// csr_ch writes page_shift, the log2 of the page size; it is always ready and
// should only be written while no request is in flight.
// One request is worked on at a time. An access or release scans the whole
// frame table through the single read port of the table memory, one frame per
// cycle. After a request is accepted, an access passes the decode, scan and commit
// states before its response is loaded in the done state; a release skips commit,
// and a request with process id zero goes from decode straight to done. The next
// request is accepted in the cycle after the response is loaded.
// A stalled receiver holds the response in the output register; one more request
// can be accepted and worked on, and it waits until the register is free.
// Reset is synchronous: all frames are free with stamp zero, the stamp counter
// restarts at one and page_shift returns to 12. No clearing pass is needed.
module lru_page_frame_replacer import lpfr_pkg::*; (
   input logic clock,
   input logic reset,
   lpfr_req_if.sink   req_ch,
   lpfr_rsp_if.source rsp_ch,
   lpfr_csr_if.sink   csr_ch
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   lpfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_ch.opcode),
      .req_pid          (req_ch.pid),
      .req_address      (req_ch.address),
      .csr_write        (csr_ch.valid),
      .csr_page_shift   (csr_ch.page_shift),
      .rsp_status       (rsp_ch.status),
      .rsp_frame        (rsp_ch.frame),
      .rsp_victim_valid (rsp_ch.victim_valid),
      .rsp_victim_pid   (rsp_ch.victim_pid)
   );

endmodule
